[src/fdxb_pkg.sv]
// ============================================================================
// fdxb_pkg
// Shared types, register indexes and frame layout constants for the FDX-B
// bi-phase frame decoder.
// ============================================================================
package fdxb_pkg;

   // port widths fixed by the field definitions
   localparam int unsigned PULSE_W     = 16;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned NATIONAL_W  = 38;
   localparam int unsigned COUNTRY_W   = 10;
   localparam int unsigned FLAG_W      = 16;
   localparam int unsigned EXTRA_W     = 24;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_MIN = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_MAX = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_MIN  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_MAX  = 8'd3;

   // threshold reset values
   localparam logic [CSR_DATA_W-1:0] SHORT_MIN_RST = 16'd68;
   localparam logic [CSR_DATA_W-1:0] SHORT_MAX_RST = 16'd188;
   localparam logic [CSR_DATA_W-1:0] LONG_MIN_RST  = 16'd196;
   localparam logic [CSR_DATA_W-1:0] LONG_MAX_RST  = 16'd316;

   // frame layout, positions counted from the oldest bit of the window
   localparam int unsigned PREAMBLE_LEN        = 11;
   localparam logic [PREAMBLE_LEN-1:0] PREAMBLE_CODE = 11'b100_0000_0000;
   localparam int unsigned SECOND_PREAMBLE_POS = 128;
   localparam int unsigned CONTROL_BASE        = 11;
   localparam int unsigned CHUNK_BASE          = 12;
   localparam int unsigned CHUNK_STRIDE        = 9;
   localparam int unsigned CHUNK_W             = 8;
   localparam int unsigned CHUNK_COUNT         = 13;
   localparam int unsigned CRC_CHUNKS          = 8;
   localparam int unsigned CRC_MSG_W           = CRC_CHUNKS * CHUNK_W;
   localparam int unsigned CRC_HI_CHUNK        = 8;
   localparam int unsigned CRC_LO_CHUNK        = 9;
   localparam int unsigned EXTRA_FIRST_CHUNK   = 10;

   localparam int unsigned CRC_W               = 16;
   localparam logic [CRC_W-1:0] CRC_POLY       = 16'h1021;
   localparam logic [CRC_W-1:0] CRC_INIT       = 16'h0000;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] short_min;
      logic [CSR_DATA_W-1:0] short_max;
      logic [CSR_DATA_W-1:0] long_min;
      logic [CSR_DATA_W-1:0] long_max;
   } thresh_type;

   typedef struct packed {
      logic is_short;
      logic is_long;
   } class_type;

   typedef struct packed {
      logic                  found;
      logic [NATIONAL_W-1:0] national;
      logic [COUNTRY_W-1:0]  country;
      logic [FLAG_W-1:0]     flags;
      logic [EXTRA_W-1:0]    extra;
   } frame_type;

   // CRC contribution of a single set message bit; bit CRC_MSG_W-1 goes first.
   // The CRC is linear with zero init, so the full CRC is the XOR of these.
   function automatic logic [CRC_W-1:0] crc_column(input int unsigned bit_idx);
      logic [CRC_W-1:0] r;
      logic             fb;
      r = CRC_INIT;
      for (int b = CRC_MSG_W - 1; b >= 0; b--) begin
         fb = r[CRC_W-1] ^ (b == int'(bit_idx));
         r  = {r[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
      end
      return r;
   endfunction

endpackage

[src/fdxb_pulse_class.sv]
// ============================================================================
// fdxb_pulse_class
// Sorts one pulse duration into the short and long windows.
// ============================================================================
module fdxb_pulse_class (
   input  fdxb_pkg::thresh_type               thresh,
   input  logic [fdxb_pkg::PULSE_W-1:0]       duration,
   output fdxb_pkg::class_type                pulse_class
);
   import fdxb_pkg::*;

   always_comb begin
      pulse_class.is_short = (duration >= thresh.short_min) &&
                             (duration <= thresh.short_max);
      pulse_class.is_long  = (duration >= thresh.long_min) &&
                             (duration <= thresh.long_max);
   end

endmodule

[src/fdxb_frame_check.sv]
// ============================================================================
// fdxb_frame_check
// Tests a bit window for a complete frame (preambles, control bits, CRC)
// and extracts the payload fields.
// ============================================================================
module fdxb_frame_check #(
   parameter int unsigned WINDOW_BITS = 144
) (
   input  logic [WINDOW_BITS-1:0] window,
   output fdxb_pkg::frame_type    frame
);
   import fdxb_pkg::*;

   // window bit at position p (0 = oldest) is window[WINDOW_BITS-1-p]
   logic [CHUNK_W-1:0]      chunk [CHUNK_COUNT];
   logic [PREAMBLE_LEN-1:0] pre_first;
   logic [PREAMBLE_LEN-1:0] pre_second;
   logic                    controls_ok;
   logic [CRC_MSG_W-1:0]    msg;
   logic [CRC_W-1:0]        crc;
   logic [CRC_W-1:0]        crc_expect;
   logic                    found;

   always_comb begin
      for (int i = 0; i < CHUNK_COUNT; i++) begin
         for (int j = 0; j < CHUNK_W; j++) begin
            chunk[i][CHUNK_W-1-j] = window[WINDOW_BITS-1-(CHUNK_BASE+CHUNK_STRIDE*i+j)];
         end
      end

      for (int j = 0; j < PREAMBLE_LEN; j++) begin
         pre_first[PREAMBLE_LEN-1-j]  = window[WINDOW_BITS-1-j];
         pre_second[PREAMBLE_LEN-1-j] = window[WINDOW_BITS-1-(SECOND_PREAMBLE_POS+j)];
      end

      controls_ok = 1'b1;
      for (int k = 0; k < CHUNK_COUNT; k++) begin
         controls_ok &= window[WINDOW_BITS-1-(CONTROL_BASE+CHUNK_STRIDE*k)];
      end

      for (int i = 0; i < CRC_CHUNKS; i++) begin
         msg[CRC_MSG_W-1-CHUNK_W*i -: CHUNK_W] = chunk[i];
      end

      // XOR of per-bit columns; folds into a flat parity tree
      crc = CRC_INIT;
      for (int b = 0; b < CRC_MSG_W; b++) begin
         if (msg[b]) begin
            crc ^= crc_column(b);
         end
      end
      crc_expect = {chunk[CRC_HI_CHUNK], chunk[CRC_LO_CHUNK]};

      found = (pre_first == PREAMBLE_CODE) && (pre_second == PREAMBLE_CODE) &&
              controls_ok && (crc == crc_expect);

      frame = '0;
      if (found) begin
         frame.found    = 1'b1;
         frame.national = msg[CRC_MSG_W-1 -: NATIONAL_W];
         frame.country  = msg[CRC_MSG_W-1-NATIONAL_W -: COUNTRY_W];
         frame.flags    = msg[FLAG_W-1:0];
         frame.extra    = {chunk[EXTRA_FIRST_CHUNK], chunk[EXTRA_FIRST_CHUNK+1],
                           chunk[EXTRA_FIRST_CHUNK+2]};
      end
   end

endmodule

[src/fdx_b_biphase_frame_decoder.sv]
// Accepted pulse words pass the input register, then the result register
// on rsp_. Throughput: one pulse word per cycle unless rsp_stall blocks;
// the pulse sort, window shift and frame check form one combinational
// pass between the input register and the result register.
// Reset (synchronous, active high): clears the bit window, the pending short
// flag and both stage valids, and loads the default pulse thresholds.
// ============================================================================
// fdx_b_biphase_frame_decoder
// Bi-phase pulse decoder with a sliding bit window and FDX-B frame detection.
// ============================================================================
module fdx_b_biphase_frame_decoder #(
   parameter int unsigned WINDOW_BITS   = 144,
   parameter int unsigned DURATION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fdxb_pkg::PULSE_W-1:0]        req_pulse_length,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_frame_found,
   output logic [fdxb_pkg::NATIONAL_W-1:0]     rsp_national_code_bits,
   output logic [fdxb_pkg::COUNTRY_W-1:0]      rsp_country_code_bits,
   output logic [fdxb_pkg::FLAG_W-1:0]         rsp_flag_bits,
   output logic [fdxb_pkg::EXTRA_W-1:0]        rsp_extra_bits,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fdxb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fdxb_pkg::CSR_DATA_W-1:0]     csr_data
);
   import fdxb_pkg::*;

   localparam int unsigned DUR_KEEP = (DURATION_BITS < PULSE_W) ? DURATION_BITS : PULSE_W;
   localparam logic [PULSE_W-1:0] DUR_MASK =
      PULSE_W'(({(PULSE_W+1){1'b0}} | 1'b1) << DUR_KEEP) - PULSE_W'(1);

   thresh_type             thresh_ff;
   logic                   a_valid_ff;
   logic [PULSE_W-1:0]     a_len_ff;
   logic                   pending_ff;
   logic                   pending_in;
   logic [WINDOW_BITS-1:0] win_ff;
   logic [WINDOW_BITS-1:0] win_in;
   logic                   rsp_valid_ff;
   frame_type              rsp_ff;
   class_type              pulse_class;
   frame_type              frame;
   logic                   pushed;
   logic                   push_bit;
   logic                   b_ready;
   logic                   load;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.short_min <= SHORT_MIN_RST;
         thresh_ff.short_max <= SHORT_MAX_RST;
         thresh_ff.long_min  <= LONG_MIN_RST;
         thresh_ff.long_max  <= LONG_MAX_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SHORT_MIN: thresh_ff.short_min <= csr_data;
            CSR_SHORT_MAX: thresh_ff.short_max <= csr_data;
            CSR_LONG_MIN:  thresh_ff.long_min  <= csr_data;
            CSR_LONG_MAX:  thresh_ff.long_max  <= csr_data;
            default: ;
         endcase
      end
   end

   // result register frees when empty or being taken
   assign b_ready   = !rsp_valid_ff || !rsp_stall;
   assign load      = a_valid_ff && b_ready;
   assign req_stall = a_valid_ff && !b_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         a_len_ff <= req_pulse_length & DUR_MASK;
      end
   end

   fdxb_pulse_class u_class (
      .thresh      (thresh_ff),
      .duration    (a_len_ff),
      .pulse_class (pulse_class)
   );

   always_comb begin
      pushed     = 1'b0;
      push_bit   = 1'b0;
      pending_in = 1'b0;
      if (pulse_class.is_short) begin
         // second short of a pair gives a zero
         pushed     = pending_ff;
         pending_in = !pending_ff;
      end else if (pulse_class.is_long) begin
         // long after a lone short: drop both
         pushed     = !pending_ff;
         push_bit   = 1'b1;
      end
      win_in = pushed ? {win_ff[WINDOW_BITS-2:0], push_bit} : win_ff;
   end

   fdxb_frame_check #(
      .WINDOW_BITS (WINDOW_BITS)
   ) u_check (
      .window (win_in),
      .frame  (frame)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         win_ff     <= '0;
      end else if (load) begin
         pending_ff <= pending_in;
         win_ff     <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (b_ready) begin
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= pushed ? frame : '0;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_frame_found        = rsp_ff.found;
   assign rsp_national_code_bits = rsp_ff.national;
   assign rsp_country_code_bits  = rsp_ff.country;
   assign rsp_flag_bits          = rsp_ff.flags;
   assign rsp_extra_bits         = rsp_ff.extra;

   a_no_frame_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_found) |->
         (rsp_national_code_bits == '0 && rsp_country_code_bits == '0 &&
          rsp_flag_bits == '0 && rsp_extra_bits == '0))
      else $error("non-frame result carries payload");

   a_window_holds : assert property (@(posedge clock) disable iff (reset)
      !load |=> $stable(win_ff) && $stable(pending_ff))
      else $error("window changed without a pulse word");

   a_frame_clears_pending : assert property (@(posedge clock) disable iff (reset)
      (load && frame.found && pushed) |=> !pending_ff)
      else $error("pending short left set after a decoded bit");

   a_stall_needs_item : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled with no blocked word");

endmodule
